FILE: rtl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg - shared types and constants of the text cell glyph renderer
// item structs, screen geometry, command codes and the 16-colour palette
// ----------------------------------------------------------------------------
package tcgr_pkg;

  // glyph and screen geometry
  localparam int GLYPH_W = 9;
  localparam int GLYPH_H = 16;
  localparam int COLS    = 80;
  localparam int ROWS    = 25;

  // font store: 256 glyphs of 16 stored rows, 9 bits each
  localparam int FONT_W     = 9;
  localparam int FONT_DEPTH = 4096;
  localparam int LINE_W     = 4;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic [3:0] glyph_line;
    logic [8:0] glyph_bits;
    logic [7:0] attribute;
    logic [6:0] cell_col;
    logic [4:0] cell_row;
    logic       cursor_on;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  screen_x;
    logic [8:0]  screen_y;
    logic [23:0] pix0;
    logic [23:0] pix1;
    logic [23:0] pix2;
    logic [23:0] pix3;
    logic [23:0] pix4;
    logic [23:0] pix5;
    logic [23:0] pix6;
    logic [23:0] pix7;
    logic [23:0] pix8;
    logic        last_line;
  } out_item_t;

  // fixed 16-colour palette, 0xRRGGBB
  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] c;
    case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'h0000AA;
      4'd2:    c = 24'h00AA00;
      4'd3:    c = 24'h00AAAA;
      4'd4:    c = 24'hAA0000;
      4'd5:    c = 24'hAA00AA;
      4'd6:    c = 24'hAA5500;
      4'd7:    c = 24'hAAAAAA;
      4'd8:    c = 24'h555555;
      4'd9:    c = 24'h5555FF;
      4'd10:   c = 24'h55FF55;
      4'd11:   c = 24'h55FFFF;
      4'd12:   c = 24'hFF5555;
      4'd13:   c = 24'hFF55FF;
      4'd14:   c = 24'hFFFF55;
      4'd15:   c = 24'hFFFFFF;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/tcgr_ram.sv
// ----------------------------------------------------------------------------
// tcgr_ram - generic single-write, single-read ram
// registered read port that holds its data while no read is issued
// ----------------------------------------------------------------------------
module tcgr_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tcgr_pixel_unit.sv
// ----------------------------------------------------------------------------
// tcgr_pixel_unit - glyph row to pixel colour unit
// turns one font row into nine palette colours plus the row coordinates
// ----------------------------------------------------------------------------
module tcgr_pixel_unit (
  input  logic [8:0]           glyph_row,
  input  logic [3:0]           fg,
  input  logic [3:0]           bg,
  input  logic                 cursor,
  input  logic [9:0]           base_x,
  input  logic [8:0]           base_y,
  input  logic [3:0]           line,
  output tcgr_pkg::out_item_t  result
);

  logic [23:0] px [9];

  always_comb begin
    for (int dx = 0; dx < 9; dx++) begin
      if (dx < tcgr_pkg::GLYPH_W) begin
        // cursor cells invert the glyph bit before colour choice
        px[dx] = tcgr_pkg::palette((glyph_row[8-dx] ^ cursor) ? fg : bg);
      end else begin
        px[dx] = 24'h000000;
      end
    end
  end

  always_comb begin
    result.screen_x  = base_x;
    result.screen_y  = base_y + 9'(line);
    result.pix0      = px[0];
    result.pix1      = px[1];
    result.pix2      = px[2];
    result.pix3      = px[3];
    result.pix4      = px[4];
    result.pix5      = px[5];
    result.pix6      = px[6];
    result.pix7      = px[7];
    result.pix8      = px[8];
    result.last_line = (line == 4'(tcgr_pkg::GLYPH_H - 1));
  end

endmodule

FILE: rtl/text_cell_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_cell_glyph_renderer - text-mode character generator
// font store of 256 glyphs; draws one text cell as GLYPH_H pixel-row results
// ----------------------------------------------------------------------------
// load transfer: written to the font store in the accept cycle, ready stays high
// draw transfer: one row per cycle while output does not stall; next item taken
//   only after every row of a draw has been read and handed to the output
//   register, set by the one font store read port feeding the row sequencer
//   plus the read and output register stages
// reset: clears sequencer and output valid; font store is not cleared and
//   holds undefined data until each row is loaded
module text_cell_glyph_renderer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcgr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcgr_pkg::out_item_t out_data
);

  typedef enum logic {
    S_IDLE,
    S_DRAW
  } state_t;

  state_t state;

  // next row to read and row whose data sits on the ram output
  logic [3:0] line;
  logic [3:0] rd_line;
  logic       rd_pending;

  // captured cell
  logic [7:0] code;
  logic [3:0] fg;
  logic [3:0] bg;
  logic       cursor;
  logic [9:0] base_x;
  logic [8:0] base_y;

  logic       in_xfer;
  logic       is_load;
  logic       draw_start;
  logic       on_screen;
  logic       load_out;
  logic       issue;
  logic       issue_last;
  logic [3:0] attr_fg;
  logic [3:0] attr_bg;
  logic [8:0] rdata;

  tcgr_pkg::out_item_t row_result;

  // ready only once every row has been read and handed to the output register
  assign in_ready   = (state == S_IDLE) && !rd_pending;
  assign in_xfer    = in_valid && in_ready;
  assign is_load    = (in_data.cmd == tcgr_pkg::CMD_LOAD);
  // off-screen cells are dropped without a result
  assign on_screen  = (32'(in_data.cell_col) < tcgr_pkg::COLS) &&
                      (32'(in_data.cell_row) < tcgr_pkg::ROWS);
  assign draw_start = in_xfer && (in_data.cmd == tcgr_pkg::CMD_DRAW) && on_screen;

  // equal colours: background becomes 15 minus foreground
  assign attr_fg = in_data.attribute[3:0];
  assign attr_bg = (in_data.attribute[7:4] == attr_fg) ? (4'hF - attr_fg)
                                                      : in_data.attribute[7:4];

  // output register takes ram data when empty or being drained
  assign load_out   = rd_pending && (!out_valid || out_ready);
  // next read only when the ram output is free or moves on this cycle
  assign issue      = (state == S_DRAW) && (!rd_pending || load_out);
  assign issue_last = (line == 4'(tcgr_pkg::GLYPH_H - 1));

  tcgr_ram #(
    .WIDTH (tcgr_pkg::FONT_W),
    .DEPTH (tcgr_pkg::FONT_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (in_xfer && is_load),
    .waddr ({in_data.char_code, in_data.glyph_line}),
    .wdata (in_data.glyph_bits),
    .re    (issue),
    .raddr ({code, line}),
    .rdata (rdata)
  );

  tcgr_pixel_unit u_pix (
    .glyph_row (rdata),
    .fg        (fg),
    .bg        (bg),
    .cursor    (cursor),
    .base_x    (base_x),
    .base_y    (base_y),
    .line      (rd_line),
    .result    (row_result)
  );

  // row sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      line       <= '0;
      rd_line    <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (draw_start) begin
            state <= S_DRAW;
            line  <= '0;
          end
        end
        S_DRAW: begin
          if (issue) begin
            line    <= line + 4'd1;
            rd_line <= line;
            if (issue_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (issue) begin
        rd_pending <= 1'b1;
      end else if (load_out) begin
        rd_pending <= 1'b0;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // cell payload, no reset needed
  always_ff @(posedge clk) begin
    if (draw_start) begin
      code   <= in_data.char_code;
      fg     <= attr_fg;
      bg     <= attr_bg;
      cursor <= in_data.cursor_on;
      base_x <= 10'(in_data.cell_col * tcgr_pkg::GLYPH_W);
      base_y <= 9'(in_data.cell_row * tcgr_pkg::GLYPH_H);
    end
    if (load_out) begin
      out_data <= row_result;
    end
  end

  // a read always leaves data waiting on the ram output
  a_issue_pending : assert property (@(posedge clk) disable iff (rst)
    issue |=> rd_pending)
    else $error("font read issued without pending data");

  // waiting ram data is never dropped while the output stalls
  a_hold_pending : assert property (@(posedge clk) disable iff (rst)
    (rd_pending && out_valid && !out_ready) |=> rd_pending)
    else $error("pending row lost under output stall");

  // an on-screen draw starts the row sequencer
  a_draw_starts : assert property (@(posedge clk) disable iff (rst)
    draw_start |=> (state == S_DRAW))
    else $error("draw accepted but sequencer idle");

  // no item is taken while rows are still being read
  a_busy : assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAW) |-> !in_ready)
    else $error("ready raised during draw");

endmodule
